// ===== sv/differential_drive_mixer_defines.svh =====
// ---------------------------------------------------------------------------
// Differential drive mixer: assertion macros
// Shared property forms for the block's checks.
// ---------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH
// same-cycle implication
`define DDM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define DDM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/ddm_pkg.sv =====
// ---------------------------------------------------------------------------
// ddm_pkg
// Types, constants and fixed-point helpers of the differential drive mixer.
// ---------------------------------------------------------------------------
package ddm_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int SINE_DEPTH = 1024;
    localparam int IDX_W      = $clog2(SINE_DEPTH + 1);
    localparam int SIN_W      = FRAC_BITS + 1;
    localparam int PH_W       = FRAC_BITS + 2;
    localparam int VAL_W      = FRAC_BITS + 4;
    localparam int MOP_W      = VAL_W + 1;
    localparam int WIDE_W     = 34;
    localparam int DIV_W      = FRAC_BITS + 3;
    localparam int QUO_W      = 2 * FRAC_BITS + 3;
    localparam int TIX_W      = SIN_W + IDX_W + 1;
    localparam int ONE_Q      = 1 << FRAC_BITS;
    localparam int HALF_Q     = 1 << (FRAC_BITS - 1);
    localparam int LOW_THR    = (ONE_Q * 2 + 5) / 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [14:0] K_RESET      = 15'd8192;
    localparam logic [16:0] GAIN_RESET   = 17'd65536;
    localparam logic [14:0] BASE_RESET   = 15'd12288;
    localparam logic [14:0] CUTOFF_RESET = 15'd1638;
    localparam logic [14:0] ALPHA_RESET  = 15'd1638;
    localparam logic [15:0] SCALE_RESET  = 16'd8192;

    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic signed [MOP_W-1:0]  t_mop;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [15:0]       t_q;
    typedef logic [SIN_W-1:0]         t_sin_tab [SINE_DEPTH+1];

    localparam t_val SAT_HI = t_val'((8 << FRAC_BITS) - 1);
    localparam t_val SAT_LO = t_val'(-(8 << FRAC_BITS));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_K      = 3'd0,
        CFG_GAIN   = 3'd1,
        CFG_BASE   = 3'd2,
        CFG_CUTOFF = 3'd3,
        CFG_ALPHA  = 3'd4,
        CFG_SCALE  = 3'd5
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_DEN_A, S_DEN_D, S_SH_MUL, S_NUM_A, S_NUM_D, S_SH_DIV, S_SH_WAIT,
        S_INERT, S_WS, S_SENS, S_SENS_WAIT, S_QS_A, S_QS_B, S_QS_C,
        S_NRM_A, S_NRM_B, S_MIX
    } t_state;

    function automatic t_val sat8(input t_wide v);
        if (v > t_wide'(SAT_HI)) return SAT_HI;
        if (v < t_wide'(SAT_LO)) return SAT_LO;
        return t_val'(v);
    endfunction

    function automatic t_q clamp1(input t_wide v);
        if (v > t_wide'(ONE_Q)) return t_q'(ONE_Q);
        if (v < -t_wide'(ONE_Q)) return t_q'(-ONE_Q);
        return t_q'(v);
    endfunction

    function automatic t_val decay(input t_val v);
        if (v > t_val'(ONE_Q)) return v - t_val'(ONE_Q);
        if (v < -t_val'(ONE_Q)) return v + t_val'(ONE_Q);
        return '0;
    endfunction

    function automatic logic [DIV_W-1:0] mag16(input t_wide v);
        return DIV_W'(v < 0 ? -v : v);
    endfunction

    // rounded product, half away from zero
    function automatic t_wide mulq(input t_mop a, input t_mop b);
        logic [MOP_W-1:0]   ma;
        logic [MOP_W-1:0]   mb;
        logic [2*MOP_W-1:0] p;
        t_wide              m;
        ma = MOP_W'(a < 0 ? -a : a);
        mb = MOP_W'(b < 0 ? -b : b);
        p  = (2*MOP_W)'(ma) * (2*MOP_W)'(mb);
        p  = (p + (2*MOP_W)'(HALF_Q)) >> FRAC_BITS;
        m  = t_wide'(p);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic logic [IDX_W-1:0] sine_index(input logic [PH_W-1:0] p);
        logic [SIN_W-1:0] arg;
        logic [TIX_W-1:0] t;
        arg = p[FRAC_BITS] ? SIN_W'(ONE_Q) - SIN_W'(p[FRAC_BITS-1:0])
                           : SIN_W'(p[FRAC_BITS-1:0]);
        t = (TIX_W'(arg) * TIX_W'(SINE_DEPTH) + TIX_W'(HALF_Q)) >> FRAC_BITS;
        if (t > TIX_W'(SINE_DEPTH)) t = TIX_W'(SINE_DEPTH);
        return t[IDX_W-1:0];
    endfunction

    // Taylor term n: divide by (2n)(2n+1)
    function automatic longint unsigned taylor_div(input longint unsigned v, input int n);
        case (n)
            1:       return v / 6;
            2:       return v / 20;
            3:       return v / 42;
            4:       return v / 72;
            5:       return v / 110;
            6:       return v / 156;
            7:       return v / 210;
            8:       return v / 272;
            9:       return v / 342;
            10:      return v / 420;
            11:      return v / 506;
            default: return v / 600;
        endcase
    endfunction

    function automatic logic [SIN_W-1:0] sine_entry(input int i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        x    = (64'd1686629713 * longint'(i)) / SINE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 12; n++) begin
            term = taylor_div((term * x2) >> 30, n);
            if ((n & 1) != 0) sum = (sum >= term) ? sum - term : 64'd0;
            else              sum = sum + term;
        end
        sum = (sum + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (sum > longint'(ONE_Q)) sum = longint'(ONE_Q);
        return SIN_W'(sum);
    endfunction

    function automatic t_sin_tab build_sine_tab();
        t_sin_tab t;
        for (int i = 0; i <= SINE_DEPTH; i++) t[i] = sine_entry(i);
        return t;
    endfunction

endpackage

// ===== sv/ddm_div.sv =====
// ---------------------------------------------------------------------------
// ddm_div
// Restoring divider, one quotient bit a cycle: round(n * ONE / d) magnitudes.
// ---------------------------------------------------------------------------
module ddm_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ddm_pkg::DIV_W-1:0] i_num,
    input  logic [ddm_pkg::DIV_W-1:0] i_den,
    output logic                      o_done,
    output logic [ddm_pkg::QUO_W-1:0] o_quot
);
    import ddm_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_den, n_den;
    logic [QUO_W-1:0] r_q, n_q;
    logic [DIV_W:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_q    = r_q;
        trial  = {r_rem, r_q[QUO_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(QUO_W - 1);
            n_rem  = '0;
            n_den  = i_den;
            n_q    = (QUO_W'(i_num) << FRAC_BITS) + QUO_W'(i_den >> 1);
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = DIV_W'(trial - {1'b0, r_den});
                n_q   = {r_q[QUO_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DIV_W-1:0];
                n_q   = {r_q[QUO_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_den <= n_den;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== sv/ddm_sine_rom.sv =====
// ---------------------------------------------------------------------------
// ddm_sine_rom
// Quarter-wave sine table, registered read.
// ---------------------------------------------------------------------------
module ddm_sine_rom (
    input  logic                      i_clk,
    input  logic [ddm_pkg::IDX_W-1:0] i_addr,
    output logic [ddm_pkg::SIN_W-1:0] o_data
);
    import ddm_pkg::*;

    localparam t_sin_tab ROM = build_sine_tab();

    logic [SIN_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

// ===== sv/differential_drive_mixer.sv =====
// ---------------------------------------------------------------------------
// differential_drive_mixer
// Throttle/steer to left/right drive mixer on a shared multiplier,
// sine table and serial divider.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one drive command per transfer; m_axis returns the
//   left and right motor commands for it, one transfer per command.
//   The cfg channel writes the six tuning registers and is always ready.
//   The user must see that it is written only while the block is idle;
//   the block itself does not enforce this. Each of the two shaping
//   passes waits on the serial divider, and the sensitivity rescale adds
//   a further division when throttle is above the cutoff. The rest are
//   single steps of the shared multiplier and three table reads. When
//   sin(pi/2*k) is zero the shaping divisions are skipped.
//   s_axis_tready is high only in idle, so a new command is not taken
//   until the previous one has passed every step.
//   A finished result sits in the output register; the next command may
//   be taken while it waits, but its own result is held back until the
//   receiver takes the previous one.
//   Synchronous reset restores register defaults and clears the steer
//   history, inertia and quick-stop accumulators.
// ---------------------------------------------------------------------------
`include "differential_drive_mixer_defines.svh"

module differential_drive_mixer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,  // throttle, steer
    input  logic                           s_axis_tuser,  // quick_turn
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,  // left_drive, right_drive
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ddm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ddm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ddm_pkg::*;

    t_state r_state, n_state;

    logic [14:0] r_k, r_base, r_cutoff, r_alpha;
    logic [16:0] r_gain;
    logic [15:0] r_scale;

    t_q   r_prev, n_prev;
    t_val r_inert, n_inert;
    t_val r_qs, n_qs;

    t_q   r_thr, n_thr;
    logic r_quick, n_quick;
    t_val r_x, n_x;
    t_val r_dw, n_dw;
    logic r_pass, n_pass;
    logic [PH_W-1:0] r_u, n_u;
    logic r_sneg, n_sneg;
    logic r_dneg, n_dneg;
    t_q   r_den, n_den;
    t_q   r_num, n_num;
    t_val r_ws, n_ws;
    t_val r_sens, n_sens;
    t_val r_t, n_t;
    t_val r_ang, n_ang;

    logic r_out_valid, n_out_valid;
    t_q   r_left, n_left;
    t_q   r_right, n_right;

    t_mop  mul_a, mul_b;
    t_wide mul_p;
    logic [PH_W-1:0]  sin_p;
    logic [SIN_W-1:0] rom_data;
    t_q    sin_val;
    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_n, div_d;
    logic [QUO_W-1:0]  div_q;
    t_wide quot_s;
    t_wide thr_w;
    logic [16:0] thr_abs;
    t_wide one_minus_base;
    t_state after_sens;
    t_state after_shape;
    t_wide ang_w, lft, rgt, one_w;

    ddm_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (sine_index(sin_p)),
        .o_data (rom_data)
    );

    ddm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_n),
        .i_den   (div_d),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign mul_p          = mulq(mul_a, mul_b);
    assign sin_val        = r_sneg ? -t_q'(rom_data) : t_q'(rom_data);
    assign quot_s         = r_dneg ? -t_wide'(div_q) : t_wide'(div_q);
    assign thr_w          = t_wide'(r_thr);
    assign thr_abs        = 17'(thr_w < 0 ? -thr_w : thr_w);
    assign one_minus_base = t_wide'(ONE_Q) - t_wide'(r_base);
    assign one_w          = t_wide'(ONE_Q);
    assign after_sens     = r_quick ? ((thr_abs < 17'(LOW_THR)) ? S_QS_A : S_MIX) : S_NRM_A;
    assign after_shape    = r_pass ? S_INERT : S_SH_MUL;

    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_inert     = r_inert;
        n_qs        = r_qs;
        n_thr       = r_thr;
        n_quick     = r_quick;
        n_x         = r_x;
        n_dw        = r_dw;
        n_pass      = r_pass;
        n_u         = r_u;
        n_sneg      = r_sneg;
        n_dneg      = r_dneg;
        n_den       = r_den;
        n_num       = r_num;
        n_ws        = r_ws;
        n_sens      = r_sens;
        n_t         = r_t;
        n_ang       = r_ang;
        n_left      = r_left;
        n_right     = r_right;
        n_out_valid = r_out_valid && !m_axis_tready;
        mul_a       = '0;
        mul_b       = '0;
        sin_p       = '0;
        div_start   = 1'b0;
        div_n       = '0;
        div_d       = '0;
        ang_w       = r_quick ? t_wide'(r_ws) : t_wide'(r_ang);
        lft         = t_wide'(sat8(thr_w + ang_w));
        rgt         = t_wide'(sat8(thr_w - ang_w));
        if (lft > one_w) begin
            if (r_quick) rgt = t_wide'(sat8(rgt - (lft - one_w)));
            lft = one_w;
        end else if (rgt > one_w) begin
            if (r_quick) lft = t_wide'(sat8(lft - (rgt - one_w)));
            rgt = one_w;
        end else if (lft < -one_w) begin
            if (r_quick) rgt = t_wide'(sat8(rgt + (-one_w - lft)));
            lft = -one_w;
        end else if (rgt < -one_w) begin
            if (r_quick) lft = t_wide'(sat8(lft + (-one_w - rgt)));
            rgt = -one_w;
        end
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_thr   = s_axis_tdata[15:0];
                    n_quick = s_axis_tuser;
                    n_x     = t_val'(t_q'(s_axis_tdata[31:16]));
                    n_dw    = t_val'(t_q'(s_axis_tdata[31:16])) - t_val'(r_prev);
                    n_prev  = s_axis_tdata[31:16];
                    n_pass  = 1'b0;
                    n_state = S_DEN_A;
                end
            end
            S_DEN_A: begin
                sin_p   = PH_W'(r_k);
                n_sneg  = sin_p[PH_W-1];
                n_state = S_DEN_D;
            end
            S_DEN_D: begin
                n_den   = sin_val;
                n_state = S_SH_MUL;
            end
            S_SH_MUL: begin
                mul_a   = t_mop'(r_k);
                mul_b   = t_mop'(r_x);
                n_u     = mul_p[PH_W-1:0];
                n_state = S_NUM_A;
            end
            S_NUM_A: begin
                sin_p   = r_u;
                n_sneg  = sin_p[PH_W-1];
                n_state = S_NUM_D;
            end
            S_NUM_D: begin
                n_num   = sin_val;
                n_state = S_SH_DIV;
            end
            S_SH_DIV: begin
                if (r_den == '0) begin
                    n_x     = (r_num > 0) ? SAT_HI : ((r_num < 0) ? SAT_LO : '0);
                    n_pass  = 1'b1;
                    n_state = after_shape;
                end else begin
                    div_start = 1'b1;
                    div_n     = mag16(t_wide'(r_num));
                    div_d     = mag16(t_wide'(r_den));
                    n_dneg    = r_num[15] ^ r_den[15];
                    n_state   = S_SH_WAIT;
                end
            end
            S_SH_WAIT: begin
                if (div_done) begin
                    n_x     = sat8(quot_s);
                    n_pass  = 1'b1;
                    n_state = after_shape;
                end
            end
            S_INERT: begin
                mul_a   = t_mop'(r_dw);
                mul_b   = t_mop'(r_gain);
                n_inert = sat8(t_wide'(r_inert) + mul_p);
                n_state = S_WS;
            end
            S_WS: begin
                n_ws    = sat8(t_wide'(r_x) + t_wide'(r_inert));
                n_inert = decay(r_inert);
                n_state = S_SENS;
            end
            S_SENS: begin
                if (thr_abs > 17'(r_cutoff)) begin
                    div_start = 1'b1;
                    div_n     = mag16(one_minus_base);
                    div_d     = DIV_W'(thr_abs);
                    n_dneg    = one_minus_base < 0;
                    n_state   = S_SENS_WAIT;
                end else begin
                    n_sens  = t_val'(r_base);
                    n_state = after_sens;
                end
            end
            S_SENS_WAIT: begin
                if (div_done) begin
                    n_sens  = sat8(one_w - quot_s);
                    n_state = after_sens;
                end
            end
            S_QS_A: begin
                mul_a   = t_mop'(clamp1(t_wide'(r_ws)));
                mul_b   = t_mop'(r_scale);
                n_t     = t_val'(mul_p);
                n_state = S_QS_B;
            end
            S_QS_B: begin
                mul_a   = t_mop'(r_alpha);
                mul_b   = t_mop'(r_t);
                n_t     = t_val'(mul_p);
                n_state = S_QS_C;
            end
            S_QS_C: begin
                mul_a   = t_mop'(one_w - t_wide'(r_alpha));
                mul_b   = t_mop'(r_qs);
                n_qs    = sat8(mul_p + t_wide'(r_t));
                n_state = S_MIX;
            end
            S_NRM_A: begin
                mul_a   = t_mop'(thr_abs);
                mul_b   = t_mop'(r_ws);
                n_t     = sat8(mul_p);
                n_state = S_NRM_B;
            end
            S_NRM_B: begin
                mul_a   = t_mop'(r_t);
                mul_b   = t_mop'(r_sens);
                n_ang   = sat8(mul_p - t_wide'(r_qs));
                n_qs    = decay(r_qs);
                n_state = S_MIX;
            end
            S_MIX: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_left      = clamp1(-lft);
                    n_right     = clamp1(rgt);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_inert <= '0;
            r_qs    <= '0;
        end else begin
            r_prev  <= n_prev;
            r_inert <= n_inert;
            r_qs    <= n_qs;
        end
        r_thr   <= n_thr;
        r_quick <= n_quick;
        r_x     <= n_x;
        r_dw    <= n_dw;
        r_pass  <= n_pass;
        r_u     <= n_u;
        r_sneg  <= n_sneg;
        r_dneg  <= n_dneg;
        r_den   <= n_den;
        r_num   <= n_num;
        r_ws    <= n_ws;
        r_sens  <= n_sens;
        r_t     <= n_t;
        r_ang   <= n_ang;
        r_left  <= n_left;
        r_right <= n_right;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= K_RESET;
            r_gain   <= GAIN_RESET;
            r_base   <= BASE_RESET;
            r_cutoff <= CUTOFF_RESET;
            r_alpha  <= ALPHA_RESET;
            r_scale  <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_K:      r_k      <= i_cfg_data[14:0];
                CFG_GAIN:   r_gain   <= i_cfg_data[16:0];
                CFG_BASE:   r_base   <= i_cfg_data[14:0];
                CFG_CUTOFF: r_cutoff <= i_cfg_data[14:0];
                CFG_ALPHA:  r_alpha  <= i_cfg_data[14:0];
                CFG_SCALE:  r_scale  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_right, r_left};

    `DDM_ASSERT_NXT(a_accept_starts, s_axis_tvalid && s_axis_tready, r_state == S_DEN_A,
        "accepted transfer did not start the sequence")
    `DDM_ASSERT_IMP(a_out_range, r_out_valid,
        (r_right <= t_q'(ONE_Q)) && (r_right >= -t_q'(ONE_Q)) &&
        (r_left <= t_q'(ONE_Q)) && (r_left >= -t_q'(ONE_Q)),
        "drive output outside unit range")
    `DDM_ASSERT_IMP(a_div_done_state, div_done,
        (r_state == S_SH_WAIT) || (r_state == S_SENS_WAIT),
        "divider finished outside a wait state")

endmodule

// ===== verif/ddm_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ddm_checker
// Watches the command, result and register channels of the drive mixer,
// predicts each pair of motor commands in fixed point and compares them
// in order against the result transfers.
// ---------------------------------------------------------------------------
module ddm_checker
    import ddm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [31:0]           m_axis_tdata,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    localparam longint ONE  = 64'sd16384;
    localparam longint TOP8 = 8 * ONE - 1;
    localparam longint BOT8 = -8 * ONE;
    localparam longint SLOW = (ONE * 2 + 5) / 10;

    typedef struct packed {
        logic [15:0] right_drive;
        logic [15:0] left_drive;
    } t_drive;

    longint sine_lut [1025];
    longint k_reg, gain_reg, base_reg, cutoff_reg, alpha_reg, scale_reg;
    longint last_steer, inertia, qstop;
    t_drive drive_q [$];

    function automatic longint mag_of(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint sat_q(longint v);
        return v > TOP8 ? TOP8 : (v < BOT8 ? BOT8 : v);
    endfunction

    function automatic longint clip_one(longint v);
        return v > ONE ? ONE : (v < -ONE ? -ONE : v);
    endfunction

    function automatic longint drop_unit(longint v);
        if (v > ONE) return v - ONE;
        if (v < -ONE) return v + ONE;
        return 0;
    endfunction

    function automatic longint prod_q(longint a, longint b);
        longint m;
        m = (mag_of(a) * mag_of(b) + ONE / 2) >>> 14;
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic longint quot_q(longint n, longint d);
        longint m;
        m = (mag_of(n) * ONE + mag_of(d) / 2) / mag_of(d);
        return ((n < 0) != (d < 0)) ? -m : m;
    endfunction

    function automatic longint lut_pick(longint r);
        longint idx;
        idx = (r * 1024 + ONE / 2) / ONE;
        if (idx > 1024) idx = 1024;
        return sine_lut[idx];
    endfunction

    function automatic longint half_sine(longint u);
        longint p, q, r;
        p = u & (4 * ONE - 1);
        q = p >>> 14;
        r = p & (ONE - 1);
        case (q)
            0: return lut_pick(r);
            1: return lut_pick(ONE - r);
            2: return -lut_pick(r);
            default: return -lut_pick(ONE - r);
        endcase
    endfunction

    function automatic longint warp(longint w);
        longint num, den;
        num = half_sine(prod_q(k_reg, w));
        den = half_sine(k_reg);
        if (den == 0) return num > 0 ? TOP8 : (num < 0 ? BOT8 : 0);
        return sat_q(quot_q(num, den));
    endfunction

    function automatic t_drive mix_drive(longint thr, longint w, logic quick);
        longint dw, ws, at, sens, ang, left, right;
        logic   over;
        t_drive res;
        dw = w - last_steer;
        last_steer = w;
        ws = warp(warp(w));
        inertia = sat_q(inertia + prod_q(dw, gain_reg));
        ws = sat_q(ws + inertia);
        inertia = drop_unit(inertia);
        at = mag_of(thr);
        sens = base_reg;
        if (at > cutoff_reg) sens = sat_q(ONE - quot_q(ONE - base_reg, at));
        if (quick) begin
            if (at < SLOW)
                qstop = sat_q(prod_q(ONE - alpha_reg, qstop)
                              + prod_q(alpha_reg, prod_q(clip_one(ws), scale_reg)));
            over = 1'b1;
            ang = ws;
        end else begin
            over = 1'b0;
            ang = sat_q(prod_q(sat_q(prod_q(at, ws)), sens) - qstop);
            qstop = drop_unit(qstop);
        end
        left = sat_q(thr + ang);
        right = sat_q(thr - ang);
        if (left > ONE) begin
            if (over) right = sat_q(right - (left - ONE));
            left = ONE;
        end else if (right > ONE) begin
            if (over) left = sat_q(left - (right - ONE));
            right = ONE;
        end else if (left < -ONE) begin
            if (over) right = sat_q(right + (-ONE - left));
            left = -ONE;
        end else if (right < -ONE) begin
            if (over) left = sat_q(left + (-ONE - right));
            right = -ONE;
        end
        res.left_drive  = 16'(clip_one(-left));
        res.right_drive = 16'(clip_one(right));
        return res;
    endfunction

    initial begin
        longint unsigned x, x2, term, sum;
        for (int i = 0; i <= 1024; i++) begin
            x = (64'd1686629713 * longint'(i)) / 1024;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) sum = (sum >= term) ? sum - term : 0;
                else sum = sum + term;
            end
            sum = (sum + (64'd1 << 15)) >> 16;
            if (sum > 16384) sum = 16384;
            sine_lut[i] = longint'(sum);
        end
    end

    assign o_pending = drive_q.size();

    always @(posedge i_clk) begin
        t_drive got, want;
        if (!i_rst_n) begin
            k_reg = 8192; gain_reg = 65536; base_reg = 12288;
            cutoff_reg = 1638; alpha_reg = 1638; scale_reg = 8192;
            last_steer = 0; inertia = 0; qstop = 0;
            drive_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_K:      k_reg      = i_cfg_data[14:0];
                    CFG_GAIN:   gain_reg   = i_cfg_data[16:0];
                    CFG_BASE:   base_reg   = i_cfg_data[14:0];
                    CFG_CUTOFF: cutoff_reg = i_cfg_data[14:0];
                    CFG_ALPHA:  alpha_reg  = i_cfg_data[14:0];
                    CFG_SCALE:  scale_reg  = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                drive_q.push_back(mix_drive(longint'($signed(s_axis_tdata[15:0])),
                                            longint'($signed(s_axis_tdata[31:16])),
                                            s_axis_tuser));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (drive_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_errors++;
                end else begin
                    want = drive_q.pop_front();
                    if (got.left_drive !== want.left_drive) begin
                        $display("%0t: left_drive expected %h actual %h",
                                 $time, want.left_drive, got.left_drive);
                        o_errors++;
                    end
                    if (got.right_drive !== want.right_drive) begin
                        $display("%0t: right_drive expected %h actual %h",
                                 $time, want.right_drive, got.right_drive);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

// ===== verif/tb_differential_drive_mixer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_differential_drive_mixer
// Drives directed and random drive commands through several register
// settings and idle patterns, with one long receiver hold-off; the
// checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_differential_drive_mixer;
    import ddm_pkg::*;

    localparam int WATCH_LIMIT = 20000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;  // throttle, steer
    logic                  s_axis_tuser = 1'b0;  // quick_turn
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;  // left_drive, right_drive
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int errors, pending;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 1'b0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    differential_drive_mixer dut (.*);

    ddm_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        while (quiet_cycles < WATCH_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_cmd(input logic [15:0] thr, input logic [15:0] str,
                            input logic qt);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {str, thr};
        s_axis_tuser  <= qt;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_q();
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'($urandom_range(32768) - 16384);
    endfunction

    task automatic set_regs(input int mode);
        case (mode)
            1: begin
                write_reg(CFG_K, 1); write_reg(CFG_GAIN, 0); write_reg(CFG_BASE, 0);
                write_reg(CFG_CUTOFF, 164); write_reg(CFG_ALPHA, 0);
                write_reg(CFG_SCALE, 0);
            end
            2: begin
                write_reg(CFG_K, 16384); write_reg(CFG_GAIN, 131071);
                write_reg(CFG_BASE, 16384); write_reg(CFG_CUTOFF, 16384);
                write_reg(CFG_ALPHA, 16384); write_reg(CFG_SCALE, 65535);
            end
            3: begin
                write_reg(CFG_K, 0); write_reg(CFG_GAIN, 'h1FFFF);
                write_reg(CFG_BASE, 'h7FFF); write_reg(CFG_CUTOFF, 0);
                write_reg(CFG_ALPHA, 'h7FFF); write_reg(CFG_SCALE, 'hFFFF);
            end
            default: begin
                write_reg(CFG_K, int'($urandom_range(16384, 1)));
                write_reg(CFG_GAIN, int'($urandom_range(131071)));
                write_reg(CFG_BASE, int'($urandom_range(16384)));
                write_reg(CFG_CUTOFF, int'($urandom_range(16384, 164)));
                write_reg(CFG_ALPHA, int'($urandom_range(16384)));
                write_reg(CFG_SCALE, int'($urandom_range(65535)));
            end
        endcase
    endtask

    initial begin
        logic [15:0] thr, str;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_cmd(16'sd0, 16'sd0, 1'b0);
        send_cmd(16'sd16384, 16'sd0, 1'b0);
        send_cmd(-16'sd16384, 16'sd16384, 1'b0);
        send_cmd(16'sd16384, -16'sd16384, 1'b0);
        send_cmd(16'sd16384, 16'sd16384, 1'b0);
        send_cmd(16'sd0, -16'sd16384, 1'b1);
        send_cmd(16'sd0, 16'sd16384, 1'b1);
        send_cmd(16'sd3276, 16'sd8000, 1'b1);
        send_cmd(16'sd3277, -16'sd8000, 1'b1);
        send_cmd(-16'sd3276, 16'sd12000, 1'b1);
        send_cmd(16'sd1000, 16'sd0, 1'b0);
        send_cmd(16'sd1638, 16'sd4000, 1'b0);
        send_cmd(16'sd1639, 16'sd4000, 1'b0);
        send_cmd(-16'sd16384, -16'sd16384, 1'b1);
        send_cmd(16'sd16384, 16'sd16384, 1'b1);
        send_cmd(16'h7FFF, 16'h8000, 1'b0);
        send_cmd(16'h8000, 16'h7FFF, 1'b1);
        send_cmd(16'sd8000, 16'sd200, 1'b0);
        send_cmd(-16'sd8000, -16'sd200, 1'b0);
        send_cmd(16'sd0, 16'sd0, 1'b0);

        for (int ph = 0; ph < 9; ph++) begin
            if (ph > 0) set_regs(ph);
            case (ph % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 61; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 61; end
                default: begin send_gap_pct = 26; recv_stall_pct = 26; end
            endcase
            if (ph == 4) hold_req = 1'b1;
            for (int n = 0; n < 175; n++) begin
                thr = rand_q();
                str = rand_q();
                if ($urandom_range(3) == 0) thr = 16'($urandom_range(6000) - 3000);
                send_cmd(thr, str, 1'($urandom));
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/ddm_pkg.sv
sv/ddm_div.sv
sv/ddm_sine_rom.sv
sv/differential_drive_mixer.sv
verif/ddm_checker.sv
verif/tb_differential_drive_mixer.sv
